// ----- hw/rtl/xps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package xps_pkg;

  // Store and layout limits.
  localparam int unsigned MAX_SHARD_BYTES = 4096;
  localparam int unsigned MAX_DATA_SHARDS = 64;

  // Field widths.
  localparam int unsigned SHARD_W  = 7;
  localparam int unsigned BYTES_W  = 13;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned ADDR_W   = $clog2(MAX_SHARD_BYTES);
  localparam int unsigned CRC_W    = 32;

  // CRC32C, reflected form.
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  // Result queue sizing.
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Configuration register indexes.
  localparam logic CFG_SHARD_COUNT = 1'b0;
  localparam logic CFG_SHARD_BYTES = 1'b1;

  typedef enum logic [1:0] {
    KIND_PARITY = 2'd0,
    KIND_CRC    = 2'd1,
    KIND_ERROR  = 2'd2
  } xps_kind_e;

  typedef struct packed {
    xps_kind_e            kind;
    logic [SHARD_W-1:0]   shard_index;
    logic [OFFSET_W-1:0]  byte_offset;
    logic [7:0]           byte_value;
    logic [CRC_W-1:0]     crc_value;
    logic                 last;
  } xps_result_t;

  // Push request from the datapath into the result queue.
  typedef struct packed {
    logic first;
    logic second;
  } xps_push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/xps_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/xps_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xps_outq
  import xps_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire xps_push_t   push_i,
  input  wire xps_result_t first_i,
  input  wire xps_result_t second_i,
  output logic             room2_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output xps_result_t      head_o
);

  xps_result_t           ent_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [OQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                  pop;

  function automatic logic [OQ_PTR_W-1:0] ptr_inc(input logic [OQ_PTR_W-1:0] p);
    ptr_inc = (p == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : p + OQ_PTR_W'(1);
  endfunction

  assign pop     = valid_o && ready_i;
  assign wr_next = ptr_inc(wr_q);

  // Pointer and fill count update; up to two words enter per cycle.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.first && push_i.second) begin
      wr_d  = ptr_inc(wr_next);
      cnt_d = cnt_d + OQ_CNT_W'(2);
    end else if (push_i.first) begin
      wr_d  = wr_next;
      cnt_d = cnt_d + OQ_CNT_W'(1);
    end
    if (pop) begin
      rd_d  = ptr_inc(rd_q);
      cnt_d = cnt_d - OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      ent_q[wr_q] <= first_i;
    end
    if (push_i.first && push_i.second) begin
      ent_q[wr_next] <= second_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_q];
  assign room2_o = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.second |-> push_i.first)
    else $error("second word pushed without first");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.first |-> (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2)) || (pop && !push_i.second &&
      cnt_q <= OQ_CNT_W'(OQ_DEPTH)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ----- hw/rtl/xor_parity_shard_encoder.sv -----
// Each accepted word is handled in order: the parity RAM is read at the byte
// offset when the word is taken, then the execute step modifies, writes back and
// updates the CRC. No new word is taken before that step is done, nor while more
// than two result words wait for the receiver; results leave via the result queue.
// Reset clears positions, phase and the result queue, sets the CRC to its initial value and both registers to 1.
// The parity RAM is not cleared; shard 0 of each run writes every offset that its read-out reads.
`timescale 1ns / 1ps
`default_nettype none

module xor_parity_shard_encoder
  import xps_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration write channel.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [BYTES_W-1:0] cfg_data_i,
  // Input words.
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,  // [7:0] data_byte
  input  wire logic               s_axis_tuser,  // [0] op
  // Result words.
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [6:0] shard_index, [18:7] byte_offset, [26:19] byte_value,
  // [58:27] crc_value, [63:59] zero
  output logic [63:0]             m_axis_tdata,
  output logic [1:0]              m_axis_tuser,  // [1:0] kind
  output logic                    m_axis_tlast   // last
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e              state_q, state_d;
  logic                op_q;
  logic [7:0]          byte_q;
  logic [OFFSET_W-1:0] pos_q, pos_d;
  logic [SHARD_W-1:0]  shard_q, shard_d;
  logic [CRC_W-1:0]    crc_q, crc_d;
  logic                phase_q, phase_d;
  logic [SHARD_W-1:0]  count_q, count_d;
  logic [BYTES_W-1:0]  bytes_q, bytes_d;

  logic                in_acc, cfg_acc, room2;
  logic [SHARD_W-1:0]  eff_cnt, shard_inc;
  logic [BYTES_W-1:0]  eff_size, pos_inc;
  logic                shard_end;
  logic [7:0]          rdata, crc_in, wdata;
  logic [CRC_W-1:0]    crc_new;
  logic                ram_we;
  xps_push_t           push;
  xps_result_t         res_a, res_b, head;

  // CRC32C byte update, one bit per step.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-8){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_byte = c;
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (state_q == ST_IDLE) && room2;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Registers clamped into their legal ranges.
  always_comb begin
    eff_cnt = count_q;
    if (count_q == '0) eff_cnt = SHARD_W'(1);
    if (count_q > SHARD_W'(MAX_DATA_SHARDS)) eff_cnt = SHARD_W'(MAX_DATA_SHARDS);
    eff_size = bytes_q;
    if (bytes_q == '0) eff_size = BYTES_W'(1);
    if (bytes_q > BYTES_W'(MAX_SHARD_BYTES)) eff_size = BYTES_W'(MAX_SHARD_BYTES);
  end

  // Parity store. A read is issued at accept and the write back comes in the
  // next cycle; no new read can start before that write, so no forwarding.
  xps_ram #(
    .WIDTH (8),
    .DEPTH (MAX_SHARD_BYTES)
  ) u_parity (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q[ADDR_W-1:0]),
    .wdata_i (wdata),
    .re_i    (in_acc),
    .raddr_i (pos_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  assign pos_inc   = {1'b0, pos_q} + BYTES_W'(1);
  assign shard_end = (pos_inc >= eff_size);
  assign shard_inc = shard_q + SHARD_W'(1);
  assign wdata     = (shard_q == '0) ? byte_q : (rdata ^ byte_q);
  assign crc_in    = op_q ? rdata : byte_q;
  assign crc_new   = crc_byte(crc_q, crc_in);

  // Execute step: write the parity RAM, update positions and CRC, build up to two results.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    shard_d = shard_q;
    crc_d   = crc_q;
    phase_d = phase_q;
    count_d = count_q;
    bytes_d = bytes_q;
    ram_we  = 1'b0;
    push    = '0;
    res_a   = '0;
    res_b   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d    = ST_IDLE;
        push.first = 1'b1;
        if (op_q != phase_q) begin
          res_a.kind        = KIND_ERROR;
          res_a.shard_index = shard_q;
          res_a.byte_offset = pos_q;
        end else if (!op_q) begin
          ram_we = 1'b1;
          if (shard_end) begin
            res_a.kind        = KIND_CRC;
            res_a.shard_index = shard_q;
            res_a.crc_value   = crc_new ^ CRC_INIT;
            pos_d = '0;
            crc_d = CRC_INIT;
            if (shard_inc >= eff_cnt) begin
              shard_d = eff_cnt;
              phase_d = 1'b1;
            end else begin
              shard_d = shard_inc;
            end
          end else begin
            push.first = 1'b0;
            pos_d = pos_inc[OFFSET_W-1:0];
            crc_d = crc_new;
          end
        end else begin
          res_a.kind        = KIND_PARITY;
          res_a.shard_index = eff_cnt;
          res_a.byte_offset = pos_q;
          res_a.byte_value  = rdata;
          if (shard_end) begin
            push.second       = 1'b1;
            res_b.kind        = KIND_CRC;
            res_b.shard_index = eff_cnt;
            res_b.crc_value   = crc_new ^ CRC_INIT;
            res_b.last        = 1'b1;
            pos_d   = '0;
            shard_d = '0;
            crc_d   = CRC_INIT;
            phase_d = 1'b0;
          end else begin
            pos_d = pos_inc[OFFSET_W-1:0];
            crc_d = crc_new;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A register write restarts the run.
    if (cfg_acc) begin
      pos_d   = '0;
      shard_d = '0;
      crc_d   = CRC_INIT;
      phase_d = 1'b0;
      unique case (cfg_index_i)
        CFG_SHARD_COUNT: count_d = cfg_data_i[SHARD_W-1:0];
        CFG_SHARD_BYTES: bytes_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      shard_q <= '0;
      crc_q   <= CRC_INIT;
      phase_q <= 1'b0;
      count_q <= SHARD_W'(1);
      bytes_q <= BYTES_W'(1);
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      shard_q <= shard_d;
      crc_q   <= crc_d;
      phase_q <= phase_d;
      count_q <= count_d;
      bytes_q <= bytes_d;
    end
  end

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
  end

  xps_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (res_a),
    .second_i (res_b),
    .room2_o  (room2),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .head_o   (head)
  );

  assign m_axis_tdata = {5'b0, head.crc_value, head.byte_value, head.byte_offset,
                         head.shard_index};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_EXEC)
    else $error("accepted word did not enter execute");

  a_readout_shard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> shard_q == eff_cnt)
    else $error("read-out phase with wrong shard position");

  a_last_is_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_CRC)
    else $error("last flag on a non-checksum word");

  a_write_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !phase_q && !op_q && state_q == ST_EXEC)
    else $error("parity write outside the loading phase");

endmodule

`default_nettype wire

// ----- test/tb_xor_parity_shard_encoder.sv -----
`timescale 1ns / 1ps

module tb_xor_parity_shard_encoder;
  import xps_pkg::*;

  // Operation codes carried in the input tuser bit.
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  // Cycles without a transfer on any channel before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Cycles to let an in-flight word settle before touching the registers.
  localparam int unsigned SETTLE_CYCLES  = 8;

  // Tracks the encoder state and holds the results it must produce.
  class encoder_scoreboard;
    xps_result_t      pending_results[$];
    logic [7:0]       parity_shadow[MAX_SHARD_BYTES];
    logic [6:0]       shard_count_reg;
    logic [12:0]      shard_bytes_reg;
    int unsigned      byte_pos;
    int unsigned      shard_pos;
    logic [CRC_W-1:0] crc_acc;
    bit               in_readout;
    int unsigned      errors;

    function new();
      foreach (parity_shadow[i]) parity_shadow[i] = 8'h00;
      shard_count_reg = 7'd1;
      shard_bytes_reg = 13'd1;
      errors = 0;
      restart();
    endfunction

    function void restart();
      byte_pos   = 0;
      shard_pos  = 0;
      crc_acc    = CRC_INIT;
      in_readout = 1'b0;
    endfunction

    function int unsigned eff_count();
      int unsigned c;
      c = shard_count_reg;
      if (c == 0) c = 1;
      if (c > MAX_DATA_SHARDS) c = MAX_DATA_SHARDS;
      return c;
    endfunction

    function int unsigned eff_bytes();
      int unsigned b;
      b = shard_bytes_reg;
      if (b == 0) b = 1;
      if (b > MAX_SHARD_BYTES) b = MAX_SHARD_BYTES;
      return b;
    endfunction

    // Reflected CRC32C, one byte, bit-serial.
    function logic [CRC_W-1:0] crc_update(logic [CRC_W-1:0] c, logic [7:0] b);
      logic [CRC_W-1:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        if (r[0]) r = (r >> 1) ^ CRC_POLY;
        else r = r >> 1;
      end
      return r;
    endfunction

    function xps_result_t make_result(xps_kind_e kind, int unsigned shard,
                                      int unsigned offset, logic [7:0] value,
                                      logic [CRC_W-1:0] crc, logic last);
      xps_result_t r;
      r.kind        = kind;
      r.shard_index = shard[SHARD_W-1:0];
      r.byte_offset = offset[OFFSET_W-1:0];
      r.byte_value  = value;
      r.crc_value   = crc;
      r.last        = last;
      return r;
    endfunction

    // Appends one expected result behind the ones already waiting.
    function void add_expected(xps_result_t r);
      pending_results = {pending_results, r};
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Any register write aborts the current run; the parity store survives.
    function void take_config(logic index, logic [BYTES_W-1:0] value);
      if (index == CFG_SHARD_COUNT) shard_count_reg = value[6:0];
      else shard_bytes_reg = value[12:0];
      restart();
    endfunction

    // Works out the results caused by one accepted input word.
    function void take_word(logic op, logic [7:0] b);
      int unsigned cnt;
      int unsigned size;
      int unsigned addr;
      logic [7:0]  v;
      cnt  = eff_count();
      size = eff_bytes();
      addr = byte_pos % MAX_SHARD_BYTES;

      // An out-of-sequence word reports where the run stands and changes nothing.
      if (op != in_readout) begin
        add_expected(make_result(KIND_ERROR, shard_pos, byte_pos, 8'h00, '0, 1'b0));
        return;
      end

      if (op == OP_DATA) begin
        if (shard_pos == 0) parity_shadow[addr] = b;
        else parity_shadow[addr] = parity_shadow[addr] ^ b;
        crc_acc = crc_update(crc_acc, b);
        byte_pos++;
        if (byte_pos < size) return;
        add_expected(make_result(KIND_CRC, shard_pos, 0, 8'h00,
                                 crc_acc ^ CRC_INIT, 1'b0));
        byte_pos = 0;
        crc_acc  = CRC_INIT;
        shard_pos++;
        if (shard_pos >= cnt) begin
          shard_pos  = cnt;
          in_readout = 1'b1;
        end
      end else begin
        v = parity_shadow[addr];
        add_expected(make_result(KIND_PARITY, cnt, byte_pos, v, '0, 1'b0));
        crc_acc = crc_update(crc_acc, v);
        byte_pos++;
        if (byte_pos < size) return;
        add_expected(make_result(KIND_CRC, cnt, 0, 8'h00,
                                 crc_acc ^ CRC_INIT, 1'b1));
        restart();
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compares one accepted result word against the oldest expectation.
    task check_word(logic [63:0] data, logic [1:0] kind, logic last);
      xps_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0d data=%h", kind, data));
        return;
      end
      e = pending_results.pop_front();
      if (kind !== e.kind)
        report($sformatf("kind got %0d exp %0d", kind, e.kind));
      if (data[6:0] !== e.shard_index)
        report($sformatf("shard_index got %0d exp %0d", data[6:0], e.shard_index));
      if (data[18:7] !== e.byte_offset)
        report($sformatf("byte_offset got %0d exp %0d", data[18:7], e.byte_offset));
      if (data[26:19] !== e.byte_value)
        report($sformatf("byte_value got %h exp %h", data[26:19], e.byte_value));
      if (data[58:27] !== e.crc_value)
        report($sformatf("crc_value got %h exp %h", data[58:27], e.crc_value));
      if (data[63:59] !== 5'd0)
        report($sformatf("pad bits got %h exp 0", data[63:59]));
      if (last !== e.last)
        report($sformatf("last got %b exp %b", last, e.last));
    endtask
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i   = 1'b0;
  logic [BYTES_W-1:0] cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata  = 8'h00;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [63:0]        m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  logic               m_axis_tlast;

  encoder_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          phase_left     = 0;
  int unsigned stall_cycles   = 0;

  xor_parity_shard_encoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver backpressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Watchdog on cycles where no word moves on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired at %0t", $realtime);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Byte values lean on the all-zero and all-one extremes.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offers one input word, with random sender gaps, and waits for its acceptance.
  task automatic send_word(logic op, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_word(op, b);
    phase_left--;
  endtask

  task automatic write_reg(logic index, logic [BYTES_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.take_config(index, value);
  endtask

  // Drains the block, then rewrites both layout registers.
  task automatic set_layout(logic [BYTES_W-1:0] count_word,
                            logic [BYTES_W-1:0] bytes_word);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_SHARD_COUNT, count_word);
    write_reg(CFG_SHARD_BYTES, bytes_word);
    cfg_valid_i <= 1'b0;
  endtask

  // One encode run with a sprinkle of out-of-sequence words; it stops early
  // once the phase budget is spent, so the next register write aborts it.
  task automatic do_run();
    int unsigned cnt;
    int unsigned size;
    cnt  = sb.eff_count();
    size = sb.eff_bytes();
    for (int s = 0; s < cnt; s++) begin
      for (int i = 0; i < size; i++) begin
        if (phase_left <= 0) return;
        if ($urandom_range(99) < 4) send_word(OP_READOUT, rand_byte());
        send_word(OP_DATA, rand_byte());
      end
    end
    for (int i = 0; i < size; i++) begin
      if (phase_left <= 0) return;
      if ($urandom_range(99) < 4) send_word(OP_DATA, rand_byte());
      send_word(OP_READOUT, rand_byte());
    end
  endtask

  task automatic set_idle_mode(int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  // Extreme layouts: each gets one run, cut short where the layout is huge.
  logic [BYTES_W-1:0] edge_counts[6] = '{13'd64, 13'd127, 13'h1F80, 13'd0, 13'd1, 13'd2};
  logic [BYTES_W-1:0] edge_bytes[6]  = '{13'd1, 13'd2, 13'h1FFF, 13'd0, 13'd4096, 13'd3};

  initial begin
    logic [BYTES_W-1:0] cnt_word;
    logic [BYTES_W-1:0] bytes_word;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset layout of one shard of one byte.
    phase_left = 1 << 30;
    send_word(OP_READOUT, 8'h00);  // read-out while loading
    send_word(OP_DATA,    8'hFF);  // single byte ends the only shard
    send_word(OP_DATA,    8'h00);  // data during read-out
    send_word(OP_READOUT, 8'hFF);  // parity end with the closing checksum
    send_word(OP_DATA,    8'h00);
    send_word(OP_READOUT, 8'h00);

    // Directed words over three shards of two bytes.
    set_layout(13'd3, 13'd2);
    send_word(OP_DATA,    8'h00);
    send_word(OP_DATA,    8'hFF);
    send_word(OP_DATA,    8'hA5);
    send_word(OP_READOUT, 8'h3C);  // mid-shard read-out
    send_word(OP_DATA,    8'h5A);
    send_word(OP_DATA,    8'hFF);
    send_word(OP_DATA,    8'h0F);
    send_word(OP_READOUT, 8'h00);
    send_word(OP_DATA,    8'hC3);  // data during read-out
    send_word(OP_READOUT, 8'hFF);

    foreach (edge_counts[i]) begin
      set_idle_mode(i);
      set_layout(edge_counts[i], edge_bytes[i]);
      phase_left = 150;
      do_run();
    end

    // Random small layouts, including junk in the unused count bits.
    for (int ph = 0; ph < 10; ph++) begin
      set_idle_mode(ph);
      cnt_word = 13'($urandom_range(1, 6));
      if ($urandom_range(1) == 1) cnt_word[12:7] = 6'($urandom_range(63));
      if ($urandom_range(4) == 0) bytes_word = 13'($urandom_range(9, 40));
      else bytes_word = 13'($urandom_range(1, 8));
      set_layout(cnt_word, bytes_word);
      phase_left = 50;
      while (phase_left > 0) do_run();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- xor_parity_shard_encoder.f -----
hw/rtl/xps_pkg.sv
hw/rtl/xps_ram.sv
hw/rtl/xps_outq.sv
hw/rtl/xor_parity_shard_encoder.sv
test/tb_xor_parity_shard_encoder.sv
